FILE: hdl/rfid_tag_poll_presence_tracker_macros.svh
// Assertion macros for the tag presence tracker.
// Used by the top level; expects signals clk and rst in scope.
`ifndef RFID_TAG_POLL_PRESENCE_TRACKER_MACROS_SVH
`define RFID_TAG_POLL_PRESENCE_TRACKER_MACROS_SVH

// same-cycle implication
`define RTPT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rtpt assertion failed");

// next-cycle implication
`define RTPT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rtpt assertion failed");

`endif

FILE: hdl/rtpt_pkg.sv
// Types and constants for the tag presence tracker.
// No dependencies.
package rtpt_pkg;

  typedef enum logic [2:0] {
    STEP_OFF       = 3'd0,
    STEP_DUE       = 3'd1,
    STEP_RESTING   = 3'd2,
    STEP_WAKING    = 3'd3,
    STEP_LISTENING = 3'd4
  } poll_step_t;

  typedef enum logic [2:0] {
    FRAME_NONE     = 3'd0,
    FRAME_WUPA     = 3'd1,
    FRAME_ANTICOLL = 3'd2,
    FRAME_HLTA     = 3'd3,
    FRAME_IDLE_OFF = 3'd4
  } frame_t;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_STOP   = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;

  localparam logic [1:0] RS_LISTENING = 2'd0;
  localparam logic [1:0] RS_ANSWER    = 2'd2;

  localparam logic       REG_LOOK_PERIOD = 1'b0;
  localparam logic       REG_MISS_LIMIT  = 1'b1;

  localparam logic [15:0] LOOK_PERIOD_RESET = 16'd100;
  localparam logic [3:0]  MISS_LIMIT_RESET  = 4'd2;
  localparam logic [7:0]  CASCADE_TAG       = 8'h88;
  localparam logic [3:0]  MISS_MAX          = 4'd15;
  localparam logic [6:0]  LEN_ATQA          = 7'd2;
  localparam logic [6:0]  LEN_UID           = 7'd5;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] now_ms;
    logic [1:0]  reply_status;
    logic [6:0]  reply_length;
    logic [7:0]  reply_byte0;
    logic [7:0]  reply_byte1;
    logic [7:0]  reply_byte2;
    logic [7:0]  reply_byte3;
    logic [7:0]  reply_byte4;
  } item_t;

  typedef struct packed {
    poll_step_t  poll_step;
    logic [31:0] look_time;
    logic [31:0] held_uid;
    logic [3:0]  miss_count;
    logic        present_flag;
    logic        read_flag;
  } state_t;

  typedef struct packed {
    logic [15:0] look_period_ms;
    logic [3:0]  miss_limit;
  } cfg_t;

  typedef struct packed {
    frame_t      send_frame;
    logic        field_on;
    logic        tag_present;
    logic        new_read;
    logic [31:0] tag_uid;
  } result_t;

endpackage

FILE: hdl/rfid_tag_poll_presence_tracker.sv
// ISO 14443-A tag presence tracker: WUPA, anticollision and HLTA sequencing.
// Depends on rtpt_pkg, rtpt_step and rfid_tag_poll_presence_tracker_macros.svh.
//
// Usage:
//   Slave stream s_*: one event per item. s_tuser carries the opcode
//   (start, stop, update); s_tdata carries time stamp and reader reply.
//   Master stream m_*: exactly one result item per event, in order.
//   cfg_we/cfg_index/cfg_data write look_period_ms (index 0) and
//   miss_limit (index 1); write only while no item is in flight.
// Timing:
//   An accepted item is held in the input register and is evaluated into
//   the result register, which drives m_tvalid. One item per cycle
//   sustained while m_tready stays high; the limit is the single
//   update of the tracker state per cycle.
// Reset (rst, synchronous): poller off, presence and UID cleared,
//   look period 100 ms, miss limit 2, both streams empty.
// Stall: when m_tready is low the result holds; the input register still
//   takes one more item if empty, then s_tready drops until the result is taken.
`include "rfid_tag_poll_presence_tracker_macros.svh"

module rfid_tag_poll_presence_tracker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // now_ms[31:0], reply_status[33:32], reply_length[40:34], reply_byte0[48:41],
  // reply_byte1[56:49], reply_byte2[64:57], reply_byte3[72:65], reply_byte4[80:73]
  input  logic [87:0] s_tdata,
  // opcode[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // send_frame[2:0], field_on[3], tag_present[4], new_read[5], tag_uid[37:6]
  output logic [39:0] m_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import rtpt_pkg::*;

  logic    in_valid;
  item_t   in_item;
  logic    out_valid;
  result_t out_res;
  state_t  st;
  state_t  st_next;
  result_t res;
  cfg_t    cfg;
  logic    out_free;
  logic    advance;

  assign out_free = !out_valid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  rtpt_step u_step (
    .item    (in_item),
    .st      (st),
    .cfg     (cfg),
    .st_next (st_next),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.look_period_ms <= LOOK_PERIOD_RESET;
      cfg.miss_limit     <= MISS_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOOK_PERIOD: cfg.look_period_ms <= cfg_data;
        REG_MISS_LIMIT:  cfg.miss_limit     <= cfg_data[3:0];
        default:         cfg.miss_limit     <= cfg.miss_limit;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.opcode       <= s_tuser;
      in_item.now_ms       <= s_tdata[31:0];
      in_item.reply_status <= s_tdata[33:32];
      in_item.reply_length <= s_tdata[40:34];
      in_item.reply_byte0  <= s_tdata[48:41];
      in_item.reply_byte1  <= s_tdata[56:49];
      in_item.reply_byte2  <= s_tdata[64:57];
      in_item.reply_byte3  <= s_tdata[72:65];
      in_item.reply_byte4  <= s_tdata[80:73];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.poll_step    <= STEP_OFF;
      st.look_time    <= 32'd0;
      st.held_uid     <= 32'd0;
      st.miss_count   <= 4'd0;
      st.present_flag <= 1'b0;
      st.read_flag    <= 1'b0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_res <= res;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_res.tag_uid, out_res.new_read, out_res.tag_present,
                     out_res.field_on, out_res.send_frame};

  `RTPT_ASSERT_NOW(a_start_sends_nothing, out_valid && out_res.field_on,
                   out_res.send_frame == FRAME_NONE)
  `RTPT_ASSERT_NEXT(a_wupa_enters_waking, advance && res.send_frame == FRAME_WUPA,
                    st.poll_step == STEP_WAKING)
  `RTPT_ASSERT_NEXT(a_input_held_on_stall, in_valid && !advance, in_valid)

endmodule

FILE: hdl/rtpt_step.sv
// Next-state and result logic for one item of the presence tracker.
// Depends on rtpt_pkg.
module rtpt_step (
  input  rtpt_pkg::item_t   item,
  input  rtpt_pkg::state_t  st,
  input  rtpt_pkg::cfg_t    cfg,
  output rtpt_pkg::state_t  st_next,
  output rtpt_pkg::result_t res
);
  import rtpt_pkg::*;

  logic [31:0] elapsed;
  logic        period_up;
  logic        pending;
  logic        clean;
  logic        got_atqa;
  logic        got_uid;
  logic        xor_ok;
  logic [3:0]  miss_inc;
  frame_t      frame;
  logic        field;

  assign elapsed   = item.now_ms - st.look_time;
  assign period_up = elapsed >= {16'd0, cfg.look_period_ms};
  assign pending   = item.reply_status == RS_LISTENING;
  assign clean     = item.reply_status == RS_ANSWER;
  assign got_atqa  = clean && (item.reply_length == LEN_ATQA);
  assign xor_ok    = (item.reply_byte0 ^ item.reply_byte1 ^ item.reply_byte2 ^
                      item.reply_byte3) == item.reply_byte4;
  assign got_uid   = clean && (item.reply_length == LEN_UID) &&
                     (item.reply_byte0 != CASCADE_TAG) && xor_ok;
  assign miss_inc  = (st.miss_count < MISS_MAX) ? st.miss_count + 4'd1 : st.miss_count;

  always_comb begin
    st_next = st;
    frame   = FRAME_NONE;
    field   = 1'b0;
    unique case (item.opcode)
      OP_START: begin
        st_next.poll_step = STEP_DUE;
        field = 1'b1;
      end
      OP_STOP: begin
        if (st.poll_step != STEP_OFF) begin
          st_next.poll_step    = STEP_OFF;
          st_next.present_flag = 1'b0;
          frame = FRAME_IDLE_OFF;
        end
      end
      OP_UPDATE: begin
        st_next.read_flag = 1'b0;
        priority if (st.poll_step == STEP_DUE ||
                     (st.poll_step == STEP_RESTING && period_up)) begin
          st_next.look_time = item.now_ms;
          st_next.poll_step = STEP_WAKING;
          frame = FRAME_WUPA;
        end else if (st.poll_step == STEP_WAKING || st.poll_step == STEP_LISTENING) begin
          priority if (pending && !period_up) begin
            frame = FRAME_NONE;
          end else if (st.poll_step == STEP_WAKING && !pending && got_atqa) begin
            st_next.poll_step = STEP_LISTENING;
            frame = FRAME_ANTICOLL;
          end else begin
            st_next.poll_step = STEP_RESTING;
            frame = FRAME_HLTA;
            if (st.poll_step == STEP_LISTENING && !pending && got_uid) begin
              st_next.held_uid     = {item.reply_byte0, item.reply_byte1,
                                      item.reply_byte2, item.reply_byte3};
              st_next.read_flag    = !st.present_flag ||
                                     (st_next.held_uid != st.held_uid);
              st_next.present_flag = 1'b1;
              st_next.miss_count   = 4'd0;
            end else if (st.present_flag) begin
              st_next.miss_count = miss_inc;
              if (miss_inc >= cfg.miss_limit) st_next.present_flag = 1'b0;
            end
          end
        end else begin
          frame = FRAME_NONE;
        end
      end
      default: begin
        frame = FRAME_NONE;
      end
    endcase
  end

  assign res.send_frame  = frame;
  assign res.field_on    = field;
  assign res.tag_present = st_next.present_flag;
  assign res.new_read    = st_next.read_flag;
  assign res.tag_uid     = st_next.held_uid;

endmodule
